@@ rtl/srp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants for the wheel status reply parser.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // byte positions within a reply
  localparam logic [CNT_W-1:0] POS_START    = 4'd0;
  localparam logic [CNT_W-1:0] POS_ID       = 4'd1;
  localparam logic [CNT_W-1:0] POS_SPEED_HI = 4'd2;
  localparam logic [CNT_W-1:0] POS_SPEED_LO = 4'd3;
  localparam logic [CNT_W-1:0] POS_TORQ_HI  = 4'd4;
  localparam logic [CNT_W-1:0] POS_TORQ_LO  = 4'd5;
  localparam logic [CNT_W-1:0] POS_RUNNING  = 4'd6;
  localparam logic [CNT_W-1:0] POS_CRC_HI   = 4'd7;
  localparam logic [CNT_W-1:0] POS_CRC_LO   = 4'd8;
  localparam logic [CNT_W-1:0] POS_FULL     = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ID  = 8'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_payload_t;

  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] wheel_speed;
    logic signed [15:0] wheel_torque;
    logic [7:0]         running_flag;
  } out_payload_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           wdata;
  } cfg_payload_t;

endpackage
`default_nettype wire

@@ rtl/srp_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srp_in_if
// Byte request channel into the parser.
// ----------------------------------------------------------------------------
interface srp_in_if;
  logic                valid;
  logic                ready;
  srp_pkg::in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/srp_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srp_out_if
// Result request channel out of the parser.
// ----------------------------------------------------------------------------
interface srp_out_if;
  logic                 valid;
  logic                 ready;
  srp_pkg::out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/srp_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srp_cfg_if
// Register write channel of the parser.
// ----------------------------------------------------------------------------
interface srp_cfg_if;
  logic                 valid;
  logic                 ready;
  srp_pkg::cfg_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/status_reply_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// status_reply_parser
// Checks a wheel status reply byte by byte and emits one verdict per buffer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  in_ch   | in  | data_byte, last_byte                            | valid/ready
//  out_ch  | out | frame_ok, wheel_speed, wheel_torque, running_flag | valid/ready
//  cfg_ch  | in  | index, wdata                                    | valid/ready
//
// One byte is taken per cycle while the input is not stalled; the result of a
// buffer appears in the output register the cycle after its last byte is taken.
// The input stalls only while a result sits in the output register and
// out_ch.ready is low. cfg_ch.ready is always high.
// Reset (rst_n low, synchronous) clears all but out_data_r and rearms the parser.
// ----------------------------------------------------------------------------
module status_reply_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  srp_in_if.sink    in_ch,
  srp_out_if.source out_ch,
  srp_cfg_if.sink   cfg_ch
);
  import srp_pkg::*;

  logic [7:0]       start_byte_r, start_byte_nxt;
  logic [7:0]       status_id_r,  status_id_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic [15:0]      crc_r,        crc_nxt;
  logic [15:0]      rx_crc_r,     rx_crc_nxt;
  logic             hdr_good_r,   hdr_good_nxt;
  logic [15:0]      speed_r,      speed_nxt;
  logic [15:0]      torque_r,     torque_nxt;
  logic [7:0]       running_r,    running_nxt;
  logic             out_valid_r,  out_valid_nxt;
  out_payload_t     out_data_r,   out_data_nxt;

  logic [15:0] crc_upd;
  logic [7:0]  b;
  logic        in_fire;
  logic        cfg_fire;
  logic        frame_ok;

  srp_crc_step u_crc (
    .crc_i  (crc_r),
    .data_i (in_ch.payload.data_byte),
    .crc_o  (crc_upd)
  );

  assign b        = in_ch.payload.data_byte;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  always_comb begin
    start_byte_nxt = start_byte_r;
    status_id_nxt  = status_id_r;
    if (cfg_fire) begin
      case (cfg_ch.payload.index)
        REG_START_BYTE: start_byte_nxt = cfg_ch.payload.wdata;
        REG_STATUS_ID:  status_id_nxt  = cfg_ch.payload.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    rx_crc_nxt   = rx_crc_r;
    hdr_good_nxt = hdr_good_r;
    speed_nxt    = speed_r;
    torque_nxt   = torque_r;
    running_nxt  = running_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    frame_ok     = 1'b0;

    if (in_fire) begin
      if (count_r < POS_FULL) begin
        if (count_r <= POS_RUNNING) begin
          crc_nxt = crc_upd;
        end
        case (count_r)
          POS_START:    if (b != start_byte_r) hdr_good_nxt = 1'b0;
          POS_ID:       if (b != status_id_r)  hdr_good_nxt = 1'b0;
          POS_SPEED_HI: speed_nxt[15:8]  = b;
          POS_SPEED_LO: speed_nxt[7:0]   = b;
          POS_TORQ_HI:  torque_nxt[15:8] = b;
          POS_TORQ_LO:  torque_nxt[7:0]  = b;
          POS_RUNNING:  running_nxt      = b;
          POS_CRC_HI:   rx_crc_nxt[15:8] = b;
          POS_CRC_LO:   rx_crc_nxt[7:0]  = b;
          default: ;
        endcase
        count_nxt = count_r + 1'b1;
      end

      if (in_ch.payload.last_byte) begin
        frame_ok = (count_nxt == POS_FULL) && hdr_good_nxt && (rx_crc_nxt == crc_nxt);
        out_valid_nxt             = 1'b1;
        out_data_nxt.frame_ok     = frame_ok;
        out_data_nxt.wheel_speed  = frame_ok ? $signed(speed_nxt)  : 16'sd0;
        out_data_nxt.wheel_torque = frame_ok ? $signed(torque_nxt) : 16'sd0;
        out_data_nxt.running_flag = frame_ok ? running_nxt : 8'd0;
        // rearm for the next buffer
        count_nxt    = POS_START;
        crc_nxt      = CRC_INIT;
        rx_crc_nxt   = 16'd0;
        hdr_good_nxt = 1'b1;
        speed_nxt    = 16'd0;
        torque_nxt   = 16'd0;
        running_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd0;
      status_id_r  <= 8'd0;
      count_r      <= POS_START;
      crc_r        <= CRC_INIT;
      rx_crc_r     <= 16'd0;
      hdr_good_r   <= 1'b1;
      speed_r      <= 16'd0;
      torque_r     <= 16'd0;
      running_r    <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      start_byte_r <= start_byte_nxt;
      status_id_r  <= status_id_nxt;
      count_r      <= count_nxt;
      crc_r        <= crc_nxt;
      rx_crc_r     <= rx_crc_nxt;
      hdr_good_r   <= hdr_good_nxt;
      speed_r      <= speed_nxt;
      torque_r     <= torque_nxt;
      running_r    <= running_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/srp_crc_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srp_crc_step
// One byte of CRC-16 CCITT, MSB first, as a combinational update.
// ----------------------------------------------------------------------------
module srp_crc_step (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);
  import srp_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {data_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule
`default_nettype wire

@@ bench/tb_status_reply_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_status_reply_parser
// Self-checking bench for the wheel status reply parser. Reply buffers are
// built with a correct or a deliberately broken header, CRC or length. They
// are pushed byte by byte with random gaps against a receiver that stalls at
// random. A scoreboard predicts one verdict per buffer and compares it field
// by field with what the parser emits.
// ----------------------------------------------------------------------------
module tb_status_reply_parser;
  import srp_pkg::*;

  localparam int          REG_COUNT    = 2;
  localparam int          TARGET_BYTES = 850;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          LONG_HOLD    = 64;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int {
    REPLY_GOOD, REPLY_LONG, REPLY_BAD_START, REPLY_BAD_ID,
    REPLY_BAD_CRC, REPLY_SHORT, REPLY_NOISE
  } reply_kind_t;

  // --------------------------------------------------------------------------
  // Verdict scoreboard: tracks the parser state and queues expected verdicts
  // --------------------------------------------------------------------------
  class reply_checker;
    logic [7:0]  start_byte;
    logic [7:0]  status_id;
    logic [3:0]  pos;
    logic [15:0] crc_acc;
    logic [15:0] crc_rx;
    logic        hdr_ok;
    logic [15:0] speed;
    logic [15:0] torque;
    logic [7:0]  running;
    out_payload_t expected_verdicts[$];
    int unsigned mismatches;

    function new();
      start_byte = 8'h00;
      status_id  = 8'h00;
      mismatches = 0;
      rearm();
    endfunction

    static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function void rearm();
      pos     = '0;
      crc_acc = CRC_INIT;
      crc_rx  = 16'h0000;
      hdr_ok  = 1'b1;
      speed   = 16'h0000;
      torque  = 16'h0000;
      running = 8'h00;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
      if (idx == REG_START_BYTE) begin
        start_byte = val;
      end else if (idx == REG_STATUS_ID) begin
        status_id = val;
      end
    endfunction

    function void note_byte(input in_payload_t p);
      out_payload_t v;
      logic ok;
      if (pos < FRAME_BYTES) begin
        if (pos == POS_START && p.data_byte != start_byte) hdr_ok = 1'b0;
        if (pos == POS_ID && p.data_byte != status_id) hdr_ok = 1'b0;
        if (pos <= POS_RUNNING) crc_acc = crc_step(crc_acc, p.data_byte);
        case (pos)
          POS_SPEED_HI: speed[15:8]  = p.data_byte;
          POS_SPEED_LO: speed[7:0]   = p.data_byte;
          POS_TORQ_HI:  torque[15:8] = p.data_byte;
          POS_TORQ_LO:  torque[7:0]  = p.data_byte;
          POS_RUNNING:  running      = p.data_byte;
          POS_CRC_HI:   crc_rx[15:8] = p.data_byte;
          POS_CRC_LO:   crc_rx[7:0]  = p.data_byte;
          default: ;
        endcase
        pos = pos + 4'd1;
      end
      if (p.last_byte) begin
        ok = (pos == POS_FULL) && hdr_ok && (crc_rx == crc_acc);
        v.frame_ok     = ok;
        v.wheel_speed  = ok ? speed : 16'h0000;
        v.wheel_torque = ok ? torque : 16'h0000;
        v.running_flag = ok ? running : 8'h00;
        expected_verdicts.push_back(v);
        rearm();
      end
    endfunction

    function void check_result(input out_payload_t got);
      out_payload_t want;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected verdict ok=%0b speed=%0d torque=%0d running=%0h",
                   $realtime, got.frame_ok, got.wheel_speed, got.wheel_torque,
                   got.running_flag);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.frame_ok !== want.frame_ok || got.wheel_speed !== want.wheel_speed ||
          got.wheel_torque !== want.wheel_torque ||
          got.running_flag !== want.running_flag) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: verdict mismatch: expected ok=%0b speed=%0d torque=%0d ",
                    "running=%0h, got ok=%0b speed=%0d torque=%0d running=%0h"},
                   $realtime, want.frame_ok, want.wheel_speed, want.wheel_torque,
                   want.running_flag, got.frame_ok, got.wheel_speed,
                   got.wheel_torque, got.running_flag);
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  srp_in_if  in_ch ();
  srp_out_if out_ch ();
  srp_cfg_if cfg_ch ();

  status_reply_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  reply_checker sb = new();

  logic [7:0]  reply_q[$];
  logic [7:0]  cur_start   = 8'h00;
  logic [7:0]  cur_id      = 8'h00;
  int unsigned in_gap_max  = 7;
  int unsigned out_gap_max = 7;
  int unsigned hold_cycles = 0;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Monitors and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.payload);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_register(cfg_ch.payload.index, cfg_ch.payload.wdata);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $realtime, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per verdict, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, out_gap_max);
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.payload.data_byte <= b;
    in_ch.payload.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_reply();
    foreach (reply_q[i]) send_byte(reply_q[i], i == reply_q.size() - 1);
  endtask

  // Build a reply buffer of len bytes; short ones are cut, long ones padded.
  task automatic fill_reply(input logic [7:0] st, input logic [7:0] id,
                            input logic [15:0] spd, input logic [15:0] trq,
                            input logic [7:0] run, input logic [15:0] flip,
                            input int unsigned len);
    logic [15:0] crc;
    logic [7:0]  pad;
    reply_q.delete();
    reply_q.push_back(st);
    reply_q.push_back(id);
    reply_q.push_back(spd[15:8]);
    reply_q.push_back(spd[7:0]);
    reply_q.push_back(trq[15:8]);
    reply_q.push_back(trq[7:0]);
    reply_q.push_back(run);
    crc = CRC_INIT;
    foreach (reply_q[i]) crc = reply_checker::crc_step(crc, reply_q[i]);
    crc = crc ^ flip;
    reply_q.push_back(crc[15:8]);
    reply_q.push_back(crc[7:0]);
    while (reply_q.size() > len) void'(reply_q.pop_back());
    while (reply_q.size() < len) begin
      pad = $urandom_range(0, 255);
      reply_q.push_back(pad);
    end
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_START_BYTE) begin
      cur_start = val;
    end else if (idx == REG_STATUS_ID) begin
      cur_id = val;
    end
  endtask

  // Drop valid and hold until every verdict is in, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned pick;
    int unsigned len;
    reply_kind_t kind;
    logic [7:0]  st;
    logic [7:0]  id;
    logic [7:0]  run;
    logic [7:0]  mask;
    logic [7:0]  junk;
    logic [15:0] spd;
    logic [15:0] trq;
    logic [15:0] flip;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: registers at reset values
    fill_reply(8'h00, 8'h00, 16'h7FFF, 16'h8000, 8'hFF, 16'h0000, 9);
    send_reply();
    fill_reply(8'h00, 8'h00, 16'h8000, 16'h7FFF, 8'h00, 16'h0001, 9);
    send_reply();
    fill_reply(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1);
    send_reply();
    fill_reply(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 8'h80, 16'h0000, 3);
    send_reply();
    drain();

    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      case (phase % 5)
        0: begin st = 8'hFF; id = 8'hFF; end
        1: begin st = 8'h00; id = 8'hFF; end
        2: begin st = 8'hFF; id = 8'h00; end
        default: begin
          st = $urandom_range(0, 255);
          id = $urandom_range(0, 255);
        end
      endcase
      program_reg(REG_START_BYTE, st);
      program_reg(REG_STATUS_ID, id);
      junk = $urandom_range(0, 255);
      program_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 255)), junk);

      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      // flood the parser while the receiver holds off
      if (phase == 1) begin
        in_gap_max  = 0;
        hold_cycles = LONG_HOLD;
      end

      repeat (15) begin
        if (bytes_sent >= TARGET_BYTES) break;
        pick = $urandom_range(0, 99);
        if (pick < 45)      kind = REPLY_GOOD;
        else if (pick < 60) kind = REPLY_LONG;
        else if (pick < 67) kind = REPLY_BAD_START;
        else if (pick < 74) kind = REPLY_BAD_ID;
        else if (pick < 81) kind = REPLY_BAD_CRC;
        else if (pick < 90) kind = REPLY_SHORT;
        else                kind = REPLY_NOISE;

        st   = cur_start;
        id   = cur_id;
        spd  = $urandom_range(0, 65535);
        trq  = $urandom_range(0, 65535);
        run  = $urandom_range(0, 255);
        flip = 16'h0000;
        len  = FRAME_BYTES;
        mask = $urandom_range(1, 255);
        case (kind)
          REPLY_LONG:      len  = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6);
          REPLY_BAD_START: st   = st ^ mask;
          REPLY_BAD_ID:    id   = id ^ mask;
          REPLY_BAD_CRC:   flip = $urandom_range(1, 65535);
          REPLY_SHORT:     len  = $urandom_range(1, FRAME_BYTES - 1);
          default: ;
        endcase
        fill_reply(st, id, spd, trq, run, flip, len);
        if (kind == REPLY_NOISE) begin
          len = $urandom_range(1, 14);
          reply_q.delete();
          repeat (len) begin
            junk = $urandom_range(0, 255);
            reply_q.push_back(junk);
          end
        end
        send_reply();
      end
      drain();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      if (sb.pending() != 0)
        $display("%0d verdicts never arrived", sb.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ status_reply_parser.f @@
rtl/srp_pkg.sv
rtl/srp_in_if.sv
rtl/srp_out_if.sv
rtl/srp_cfg_if.sv
rtl/srp_crc_step.sv
rtl/status_reply_parser.sv
bench/tb_status_reply_parser.sv
